// ----- sv/fat12_fat16_table_engine_core_assert.svh -----
// Assertion macros for the FAT table engine.
`ifndef FAT12_FAT16_TABLE_ENGINE_CORE_ASSERT_SVH
`define FAT12_FAT16_TABLE_ENGINE_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FATTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fatte assertion failed");

// Antecedent implies consequent in the next cycle.
`define FATTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fatte assertion failed");

`endif

// ----- sv/fatte_pkg.sv -----
// Shared types and constants of the FAT table engine.
package fatte_pkg;

    localparam int TABLE_BYTES = 8192;
    localparam int ADDR_W      = $clog2(TABLE_BYTES);

    localparam logic [11:0] END12      = 12'hff8;
    localparam logic [15:0] END16      = 16'hfff8;
    localparam logic [7:0]  MEDIA_BYTE = 8'hf8;
    localparam logic [7:0]  LO_NIB     = 8'h0f;
    localparam logic [7:0]  HI_NIB     = 8'hf0;
    localparam logic [7:0]  FILL_BYTE  = 8'hff;

    typedef enum logic [2:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_FOLLOW = 3'd2,
        KIND_FREE   = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_LOAD   = 3'd5,
        KIND_RBYTE  = 3'd6,
        KIND_NONE   = 3'd7
    } kind_t;

    typedef enum logic {
        CFG_FAT16_MODE  = 1'b0,
        CFG_MAX_CLUSTER = 1'b1
    } cfg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RD_A = 8'b0000_0010,
        ST_RD_B = 8'b0000_0100,
        ST_EVAL = 8'b0000_1000,
        ST_WR2  = 8'b0001_0000,
        ST_CLR  = 8'b0010_0000,
        ST_BYTE = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [15:0] value_out;
        logic [11:0] index_out;
        logic        found;
        logic [7:0]  byte_out;
    } result_t;

endpackage

// ----- sv/fatte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fatte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/fat12_fat16_table_engine_core.sv -----
// FAT12/FAT16 allocation table engine: table store, request sequencer and stream ports.
//
// One request is taken at a time; every request gives one result on the m_ side.
// The table lives in one byte-wide RAM with one write and one registered read port,
// so an entry costs two byte reads. Reads and follows pass RD_A, RD_B, EVAL and DONE;
// a write adds WR2; a byte read passes BYTE, EVAL, DONE, a load BYTE, DONE, a no-op DONE;
// find next free repeats RD_A, RD_B, EVAL per entry visited; clear sweeps the whole store
// with writes in CLR. A new request is taken while a result still waits on m_.
module fat12_fat16_table_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // kind
    input  logic [55:0] s_tdata,   // entry_index, entry_value, byte_address, byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_out, index_out, found, byte_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW = fatte_pkg::ADDR_W;

    fatte_pkg::state_t  state_reg, state_next;
    fatte_pkg::kind_t   kind_reg;
    fatte_pkg::result_t res_reg, res_next, mout_reg;
    logic               mvalid_reg;
    logic               fat16_reg;
    logic [12:0]        maxcl_reg;
    logic [11:0]        idx_reg;
    logic [15:0]        val_reg;
    logic [AW-1:0]      baddr_reg;
    logic [7:0]         bin_reg;
    logic [12:0]        cur_reg, cur_next;
    logic [7:0]         b0_reg, w1_reg;
    logic [AW-1:0]      clr_reg;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [7:0]         wdata, rdata, w1_next;
    logic [AW-1:0]      off0, off1;
    logic [15:0]        entry;
    logic               out_free, accept, in_range;
    logic [12:0]        cand;
    logic [13:0]        cur_plus2;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == fatte_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !mvalid_reg || m_tready;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {3'b000, mout_reg.byte_out, mout_reg.found,
                        mout_reg.index_out, mout_reg.value_out};

    // byte offset of entry cur_reg and of the byte after it
    always_comb begin
        if (fat16_reg) begin
            off0 = AW'({cur_reg[11:0], 1'b0});
        end else begin
            off0 = AW'({1'b0, cur_reg[11:0]} + {2'b00, cur_reg[11:1]});
        end
        off1 = off0 + AW'(1);
    end

    always_comb begin
        if (fat16_reg) begin
            entry = {rdata, b0_reg};
        end else if (!cur_reg[0]) begin
            entry = {4'h0, rdata[3:0], b0_reg};
        end else begin
            entry = {4'h0, rdata, b0_reg[7:4]};
        end
    end

    // next entry the free search would visit
    assign cand      = (state_reg == fatte_pkg::ST_IDLE) ? {1'b0, s_tdata[11:0]} + 13'd1
                                                         : cur_reg + 13'd1;
    assign cur_plus2 = {1'b0, cand} + 14'd2;
    assign in_range  = (cur_plus2 <= {1'b0, maxcl_reg}) && !cand[12];

    fatte_ram #(.WIDTH(8), .DEPTH(fatte_pkg::TABLE_BYTES)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cur_next   = cur_reg + 13'd1;
        we         = 1'b0;
        waddr      = off0;
        wdata      = val_reg[7:0];
        raddr      = off0;
        w1_next    = w1_reg;
        unique case (state_reg)
            fatte_pkg::ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    cur_next = {1'b0, s_tdata[11:0]} + 13'd1;
                    unique case (fatte_pkg::kind_t'(s_tuser))
                        fatte_pkg::KIND_READ, fatte_pkg::KIND_WRITE,
                        fatte_pkg::KIND_FOLLOW: begin
                            cur_next   = {1'b0, s_tdata[11:0]};
                            state_next = fatte_pkg::ST_RD_A;
                        end
                        fatte_pkg::KIND_FREE: begin
                            res_next.index_out = s_tdata[11:0];
                            state_next = in_range ? fatte_pkg::ST_RD_A
                                                  : fatte_pkg::ST_DONE;
                        end
                        fatte_pkg::KIND_CLEAR: state_next = fatte_pkg::ST_CLR;
                        fatte_pkg::KIND_LOAD,
                        fatte_pkg::KIND_RBYTE: state_next = fatte_pkg::ST_BYTE;
                        default:               state_next = fatte_pkg::ST_DONE;
                    endcase
                end
            end
            fatte_pkg::ST_RD_A: begin
                cur_next   = cur_reg;
                raddr      = off0;
                state_next = fatte_pkg::ST_RD_B;
            end
            fatte_pkg::ST_RD_B: begin
                cur_next   = cur_reg;
                raddr      = off1;
                state_next = fatte_pkg::ST_EVAL;
            end
            fatte_pkg::ST_EVAL: begin
                state_next = fatte_pkg::ST_DONE;
                case (kind_reg)
                    fatte_pkg::KIND_READ: begin
                        cur_next           = cur_reg;
                        res_next.value_out = entry;
                        res_next.index_out = idx_reg;
                    end
                    fatte_pkg::KIND_FOLLOW: begin
                        cur_next           = cur_reg;
                        res_next.value_out = entry;
                        res_next.index_out = entry[11:0];
                        res_next.found     = fat16_reg ? (entry < fatte_pkg::END16)
                                                       : (entry[11:0] < fatte_pkg::END12);
                    end
                    fatte_pkg::KIND_WRITE: begin
                        cur_next           = cur_reg;
                        res_next.index_out = idx_reg;
                        we                 = 1'b1;
                        waddr              = off0;
                        if (fat16_reg) begin
                            wdata   = val_reg[7:0];
                            w1_next = val_reg[15:8];
                        end else if (!cur_reg[0]) begin
                            wdata   = val_reg[7:0];
                            w1_next = (rdata & fatte_pkg::HI_NIB) | {4'h0, val_reg[11:8]};
                        end else begin
                            wdata   = (b0_reg & fatte_pkg::LO_NIB) | {val_reg[3:0], 4'h0};
                            w1_next = val_reg[11:4];
                        end
                        state_next = fatte_pkg::ST_WR2;
                    end
                    fatte_pkg::KIND_RBYTE: begin
                        cur_next          = cur_reg;
                        res_next.byte_out = rdata;
                    end
                    fatte_pkg::KIND_FREE: begin
                        if (entry == 16'h0000) begin
                            cur_next           = cur_reg;
                            res_next.index_out = cur_reg[11:0];
                            res_next.found     = 1'b1;
                        end else if (in_range) begin
                            state_next = fatte_pkg::ST_RD_A;
                        end
                    end
                    default: cur_next = cur_reg;
                endcase
            end
            fatte_pkg::ST_WR2: begin
                cur_next   = cur_reg;
                we         = 1'b1;
                waddr      = off1;
                wdata      = w1_reg;
                state_next = fatte_pkg::ST_DONE;
            end
            fatte_pkg::ST_CLR: begin
                cur_next = cur_reg;
                we       = 1'b1;
                waddr    = clr_reg;
                if (clr_reg == AW'(0)) begin
                    wdata = fatte_pkg::MEDIA_BYTE;
                end else if (clr_reg == AW'(1) || clr_reg == AW'(2)
                             || (clr_reg == AW'(3) && fat16_reg)) begin
                    wdata = fatte_pkg::FILL_BYTE;
                end else begin
                    wdata = 8'h00;
                end
                if (clr_reg == AW'(fatte_pkg::TABLE_BYTES - 1)) begin
                    state_next = fatte_pkg::ST_DONE;
                end
            end
            fatte_pkg::ST_BYTE: begin
                cur_next = cur_reg;
                raddr    = baddr_reg;
                waddr    = baddr_reg;
                wdata    = bin_reg;
                if (kind_reg == fatte_pkg::KIND_LOAD) begin
                    we         = 1'b1;
                    state_next = fatte_pkg::ST_DONE;
                end else begin
                    state_next = fatte_pkg::ST_EVAL;
                end
            end
            fatte_pkg::ST_DONE: begin
                cur_next = cur_reg;
                if (out_free) begin
                    state_next = fatte_pkg::ST_IDLE;
                end
            end
            default: state_next = fatte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= fatte_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            fat16_reg  <= 1'b0;
            maxcl_reg  <= 13'd4097;
            clr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (fatte_pkg::cfg_index_t'(cfg_index))
                    fatte_pkg::CFG_FAT16_MODE:  fat16_reg <= cfg_data[0];
                    fatte_pkg::CFG_MAX_CLUSTER: maxcl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == fatte_pkg::ST_DONE && out_free) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            if (state_reg == fatte_pkg::ST_CLR) begin
                clr_reg <= clr_reg + AW'(1);
            end else begin
                clr_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        cur_reg <= cur_next;
        w1_reg  <= w1_next;
        if (state_reg == fatte_pkg::ST_RD_B) begin
            b0_reg <= rdata;
        end
        if (accept) begin
            kind_reg  <= fatte_pkg::kind_t'(s_tuser);
            idx_reg   <= s_tdata[11:0];
            val_reg   <= s_tdata[27:12];
            baddr_reg <= AW'(s_tdata[40:28]);
            bin_reg   <= s_tdata[48:41];
        end
        if (state_reg == fatte_pkg::ST_DONE && out_free) begin
            mout_reg <= res_reg;
        end
    end

`include "fat12_fat16_table_engine_core_assert.svh"

    `FATTE_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
    `FATTE_ASSERT_NEXT(a_done_loads_out, state_reg == fatte_pkg::ST_DONE && out_free, m_tvalid)
    `FATTE_ASSERT_NOW(a_write_states, we, state_reg != fatte_pkg::ST_IDLE
        && state_reg != fatte_pkg::ST_DONE && state_reg != fatte_pkg::ST_RD_A)

endmodule
